// File: rtl/core/cbs_pkg.sv
// Shared types and constants of the Cascade binary search step block.
`default_nettype none

package cbs_pkg;

    localparam int POS_W   = 12;   // key bit position field width
    localparam int ENT_W   = 8;    // entry number field width
    localparam int IV_W    = 13;   // stored interval bound (start or end plus one)
    localparam int CNT_W   = 16;   // saturating counter width
    localparam int WORD_W  = 32;   // key store word width
    localparam int WSEL_W  = 5;    // bit select inside one word
    localparam int WIDX_W  = POS_W - WSEL_W;

    localparam int KEY_BITS_DEF    = 4096;
    localparam int MAX_ENTRIES_DEF = 256;

    localparam logic [1:0] OP_KEY_WRITE = 2'd0;
    localparam logic [1:0] OP_INSTALL   = 2'd1;
    localparam logic [1:0] OP_STEP      = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic accept;      // latch the input request
        logic key_rd;      // read the key word that holds the addressed bit
        logic key_wr;      // write that word back with the bit changed
        logic flip;        // the bit is inverted rather than loaded
        logic flip_leak;   // a flip also discloses one parity bit
        logic flip_empty;  // a flip retires the interval
        logic kpos_s;      // address the key bit at the interval start
        logic ent_inst;    // install an interval
        logic ent_rd;      // read an interval table entry
        logic ent_ld;      // load and narrow the interval
        logic ent_wb;      // write the interval back
        logic par_start;   // start a parity pass over the lower half
        logic decide;      // halve the interval on the parity comparison
        logic set_par;     // report the parity and count two disclosed bits
        logic finish;      // load the result registers
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       ent_ok;
        logic       empty;
        logic       single;
        logic       par_busy;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/core/cbs_datapath.sv
// Datapath: key store, interval table, parity engine, counters and result registers.
`default_nettype none

module cbs_datapath #(
    parameter int KEY_BITS    = 4096,
    parameter int MAX_ENTRIES = 256
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  cbs_pkg::t_cmd         i_cmd,
    output cbs_pkg::t_stat              o_stat,
    input  wire  [1:0]                  i_operation,
    input  wire  [cbs_pkg::POS_W-1:0]   i_bit_position,
    input  wire                         i_bit_value,
    input  wire  [cbs_pkg::ENT_W-1:0]   i_entry_number,
    input  wire  [cbs_pkg::POS_W-1:0]   i_start_position,
    input  wire  [cbs_pkg::POS_W-1:0]   i_end_position,
    input  wire                         i_remote_match,
    input  wire                         i_remote_parity,
    output logic                        o_match_bit,
    output logic                        o_parity_bit,
    output logic                        o_corrected,
    output logic                        o_interval_empty,
    output logic [cbs_pkg::CNT_W-1:0]   o_errors_fixed,
    output logic [cbs_pkg::CNT_W-1:0]   o_leaked_bits
);
    import cbs_pkg::*;

    localparam int KW_DEPTH = (KEY_BITS + WORD_W - 1) / WORD_W;
    localparam int KW_AW    = (KW_DEPTH > 1) ? $clog2(KW_DEPTH) : 1;
    localparam int EA_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [WORD_W-1:0]     r_key_mem [KW_DEPTH];
    logic [2*IV_W-1:0]     r_ent_mem [MAX_ENTRIES];

    logic [1:0]            r_op;
    logic [POS_W-1:0]      r_kpos;
    logic                  r_bitval;
    logic [ENT_W-1:0]      r_entry;
    logic [POS_W-1:0]      r_spos;
    logic [POS_W-1:0]      r_epos;
    logic                  r_rmatch;
    logic                  r_rpar;
    logic [IV_W-1:0]       r_s;
    logic [IV_W-1:0]       r_ep1;
    logic [WORD_W-1:0]     r_kdata;
    logic [2*IV_W-1:0]     r_edata;
    logic                  r_m;
    logic                  r_par;
    logic                  r_corr;
    logic [CNT_W-1:0]      r_fixed;
    logic [CNT_W-1:0]      r_leak;

    // Parity engine: an issue stage walks the words, a data stage folds them.
    logic                  r_piss;
    logic [WIDX_W-1:0]     r_pw;
    logic [WIDX_W-1:0]     r_plast;
    logic                  r_pv;
    logic [WIDX_W-1:0]     r_pdw;
    logic [IV_W-1:0]       r_plo;
    logic [IV_W-1:0]       r_phi;
    logic                  r_acc;

    logic                  ent_ok;
    logic                  key_ok;
    logic [IV_W-1:0]       len;
    logic [IV_W-1:0]       half_end;
    logic [IV_W-1:0]       e_s;
    logic [IV_W-1:0]       e_ep1;
    logic [IV_W-1:0]       e_len;
    logic [IV_W-1:0]       inst_ep1;
    logic                  inst_empty;
    logic [KW_AW-1:0]      key_addr;
    logic                  key_rd_en;
    logic [WORD_W-1:0]     key_wdata;
    logic [WORD_W-1:0]     pmask;
    logic [IV_W-1:0]       last_pos;
    logic [CNT_W:0]        leak_sum;
    logic [1:0]            leak_add;

    assign ent_ok   = 32'(r_entry) < MAX_ENTRIES;
    assign key_ok   = 32'(r_kpos) < KEY_BITS;
    assign len      = r_ep1 - r_s;
    assign half_end = r_s + (len >> 1);
    assign e_s      = r_edata[2*IV_W-1:IV_W];
    assign e_ep1    = r_edata[IV_W-1:0];
    assign e_len    = e_ep1 - e_s;
    assign inst_empty = r_epos < r_spos;
    assign inst_ep1 = inst_empty ? IV_W'(r_spos) : IV_W'(r_epos) + IV_W'(1);
    assign last_pos = half_end - IV_W'(1);

    assign o_stat.op       = r_op;
    assign o_stat.ent_ok   = ent_ok;
    assign o_stat.empty    = r_s >= r_ep1;
    assign o_stat.single   = (r_ep1 > r_s) && (len == IV_W'(1));
    assign o_stat.par_busy = r_piss | r_pv;

    always_comb begin
        key_rd_en = i_cmd.key_rd || r_piss;
        key_addr  = r_piss ? KW_AW'(r_pw) : KW_AW'(r_kpos[POS_W-1:WSEL_W]);
        key_wdata = r_kdata;
        key_wdata[r_kpos[WSEL_W-1:0]] = i_cmd.flip ? ~r_kdata[r_kpos[WSEL_W-1:0]] : r_bitval;
        for (int j = 0; j < WORD_W; j++) begin
            pmask[j] = ({1'b0, r_pdw, WSEL_W'(j)} >= r_plo)
                    && ({1'b0, r_pdw, WSEL_W'(j)} < r_phi)
                    && (32'({r_pdw, WSEL_W'(j)}) < KEY_BITS);
        end
        leak_add = i_cmd.set_par ? 2'd2 : ((i_cmd.key_wr && i_cmd.flip_leak) ? 2'd1 : 2'd0);
        leak_sum = {1'b0, r_leak} + (CNT_W + 1)'(leak_add);
    end

    always_ff @(posedge i_clk) begin
        if (key_rd_en) begin
            r_kdata <= r_key_mem[key_addr];
        end
        if (i_cmd.key_wr && key_ok) begin
            r_key_mem[KW_AW'(r_kpos[POS_W-1:WSEL_W])] <= key_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_rd) begin
            r_edata <= r_ent_mem[EA_W'(r_entry)];
        end
        if (i_cmd.ent_inst && ent_ok) begin
            r_ent_mem[EA_W'(r_entry)] <= {IV_W'(r_spos), inst_ep1};
        end else if (i_cmd.ent_wb) begin
            r_ent_mem[EA_W'(r_entry)] <= {r_s, r_ep1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_operation;
            r_kpos   <= i_bit_position;
            r_bitval <= i_bit_value;
            r_entry  <= i_entry_number;
            r_spos   <= i_start_position;
            r_epos   <= i_end_position;
            r_rmatch <= i_remote_match;
            r_rpar   <= i_remote_parity;
            r_m      <= 1'b0;
            r_par    <= 1'b0;
            r_corr   <= 1'b0;
        end
        if (i_cmd.kpos_s) begin
            r_kpos <= r_s[POS_W-1:0];
        end
        if (i_cmd.ent_ld) begin
            r_s   <= e_s;
            r_ep1 <= e_ep1;
            if (e_s < e_ep1) begin
                if (r_rmatch) begin
                    r_s <= e_s + (e_len >> 1);
                end else begin
                    r_ep1 <= e_s + (e_len >> 1);
                end
            end
        end
        if (i_cmd.decide) begin
            if (r_acc == r_rpar) begin
                r_s <= half_end;
                r_m <= 1'b1;
            end else begin
                r_ep1 <= half_end;
            end
        end
        if (i_cmd.key_wr && i_cmd.flip) begin
            r_corr <= 1'b1;
            if (i_cmd.flip_empty) begin
                r_s <= r_ep1;
            end
        end
        if (i_cmd.set_par) begin
            r_par <= r_acc;
        end
        if (i_cmd.par_start) begin
            r_plo   <= r_s;
            r_phi   <= half_end;
            r_pw    <= r_s[POS_W-1:WSEL_W];
            r_plast <= last_pos[POS_W-1:WSEL_W];
        end
        if (r_piss) begin
            r_pdw <= r_pw;
            r_pw  <= r_pw + WIDX_W'(1);
        end
        if (i_cmd.finish) begin
            o_match_bit  <= r_m;
            o_parity_bit <= r_par;
            o_corrected  <= r_corr;
            unique case (r_op)
                OP_STEP:    o_interval_empty <= !ent_ok || (r_s >= r_ep1);
                OP_INSTALL: o_interval_empty <= ent_ok && inst_empty;
                default:    o_interval_empty <= 1'b0;
            endcase
            o_errors_fixed <= r_fixed;
            o_leaked_bits  <= r_leak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piss  <= 1'b0;
            r_pv    <= 1'b0;
            r_acc   <= 1'b0;
            r_fixed <= '0;
            r_leak  <= '0;
        end else begin
            r_pv <= r_piss;
            if (i_cmd.par_start) begin
                r_piss <= 1'b1;
                r_acc  <= 1'b0;
            end else begin
                if (r_piss && r_pw == r_plast) begin
                    r_piss <= 1'b0;
                end
                if (r_pv) begin
                    r_acc <= r_acc ^ (^(r_kdata & pmask));
                end
            end
            if (i_cmd.key_wr && i_cmd.flip && r_fixed != CNT_MAX) begin
                r_fixed <= r_fixed + CNT_W'(1);
            end
            if (leak_add != 2'd0) begin
                r_leak <= leak_sum[CNT_W] ? CNT_MAX : leak_sum[CNT_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/cbs_ctrl.sv
// Controller: sequences key writes, installs and search steps over the datapath.
`default_nettype none

module cbs_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire                  i_stall,
    input  wire  cbs_pkg::t_stat i_stat,
    output cbs_pkg::t_cmd        o_cmd
);
    import cbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_KEY_RD, S_KEY_WR, S_INSTALL, S_ENT_RD, S_ENT_LD,
        S_CHECK1, S_PAR1, S_DECIDE, S_CHECK2, S_PAR2, S_FLIP_RD, S_FLIP_WR,
        S_WB, S_OUT
    } t_state;

    t_state r_state;
    logic   r_late;
    logic   accept;
    logic   done;

    assign o_stall = r_state != S_IDLE;
    assign accept  = i_valid && !o_stall;
    assign done    = (r_state == S_OUT) && (!o_valid || !i_stall);

    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = accept;
        o_cmd.finish     = done;
        unique case (r_state)
            S_KEY_RD:  o_cmd.key_rd = 1'b1;
            S_KEY_WR:  o_cmd.key_wr = 1'b1;
            S_INSTALL: o_cmd.ent_inst = 1'b1;
            S_ENT_RD:  o_cmd.ent_rd = 1'b1;
            S_ENT_LD:  o_cmd.ent_ld = 1'b1;
            S_CHECK1: begin
                o_cmd.kpos_s    = 1'b1;
                o_cmd.par_start = !i_stat.empty && !i_stat.single;
            end
            S_DECIDE:  o_cmd.decide = !i_stat.par_busy;
            S_CHECK2: begin
                o_cmd.kpos_s    = 1'b1;
                o_cmd.par_start = !i_stat.single;
            end
            S_PAR2:    o_cmd.set_par = !i_stat.par_busy;
            S_FLIP_RD: o_cmd.key_rd = 1'b1;
            S_FLIP_WR: begin
                o_cmd.key_wr     = 1'b1;
                o_cmd.flip       = 1'b1;
                o_cmd.flip_leak  = r_late;
                o_cmd.flip_empty = !r_late;
            end
            S_WB:      o_cmd.ent_wb = 1'b1;
            default:   o_cmd.accept = accept;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_late  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (done) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    priority if (i_stat.op == OP_KEY_WRITE) begin
                        r_state <= S_KEY_RD;
                    end else if (i_stat.op == OP_INSTALL) begin
                        r_state <= S_INSTALL;
                    end else if (i_stat.op == OP_STEP && i_stat.ent_ok) begin
                        r_state <= S_ENT_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_KEY_RD:  r_state <= S_KEY_WR;
                S_KEY_WR:  r_state <= S_OUT;
                S_INSTALL: r_state <= S_OUT;
                S_ENT_RD:  r_state <= S_ENT_LD;
                S_ENT_LD:  r_state <= S_CHECK1;
                S_CHECK1: begin
                    r_late <= 1'b0;
                    priority if (i_stat.empty) begin
                        r_state <= S_WB;
                    end else if (i_stat.single) begin
                        r_state <= S_FLIP_RD;
                    end else begin
                        r_state <= S_PAR1;
                    end
                end
                S_PAR1:    r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (!i_stat.par_busy) begin
                        r_state <= S_CHECK2;
                    end
                end
                S_CHECK2: begin
                    r_late <= 1'b1;
                    r_state <= i_stat.single ? S_FLIP_RD : S_PAR2;
                end
                S_PAR2: begin
                    if (!i_stat.par_busy) begin
                        r_state <= S_WB;
                    end
                end
                S_FLIP_RD: r_state <= S_FLIP_WR;
                S_FLIP_WR: r_state <= S_WB;
                S_WB:      r_state <= S_OUT;
                S_OUT: begin
                    if (done) begin
                        r_state <= S_IDLE;
                    end
                end
                default:   r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/cascade_binary_search_step.sv
// Top level of the receiving-side Cascade binary search step block.
// A search step runs up to two parity passes over the key store, one 32-bit key word a cycle.
// Requests: one at a time; the next request is taken once the previous one has its result
// registered and the controller is back in its idle state.
// Reset: synchronous, active low; clears the controller, the result valid and both counters.
// Key store and interval table contents are not cleared and hold nothing useful until written.
`default_nettype none

module cascade_binary_search_step #(
    parameter int KEY_BITS    = cbs_pkg::KEY_BITS_DEF,
    parameter int MAX_ENTRIES = cbs_pkg::MAX_ENTRIES_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire  [1:0]                  i_operation,
    input  wire  [cbs_pkg::POS_W-1:0]   i_bit_position,
    input  wire                         i_bit_value,
    input  wire  [cbs_pkg::ENT_W-1:0]   i_entry_number,
    input  wire  [cbs_pkg::POS_W-1:0]   i_start_position,
    input  wire  [cbs_pkg::POS_W-1:0]   i_end_position,
    input  wire                         i_remote_match,
    input  wire                         i_remote_parity,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic                        o_match_bit,
    output logic                        o_parity_bit,
    output logic                        o_corrected,
    output logic                        o_interval_empty,
    output logic [cbs_pkg::CNT_W-1:0]   o_errors_fixed,
    output logic [cbs_pkg::CNT_W-1:0]   o_leaked_bits
);
    import cbs_pkg::*;

    // The controller only sees status flags and issues one command set per
    // cycle; all storage and arithmetic lives in the datapath.
    t_cmd  cmd;
    t_stat stat;

    cbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // The result registers sit in the datapath, so a finished result can wait
    // for the consumer while the next request is already being worked on.
    cbs_datapath #(
        .KEY_BITS    (KEY_BITS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_operation),
        .i_bit_position   (i_bit_position),
        .i_bit_value      (i_bit_value),
        .i_entry_number   (i_entry_number),
        .i_start_position (i_start_position),
        .i_end_position   (i_end_position),
        .i_remote_match   (i_remote_match),
        .i_remote_parity  (i_remote_parity),
        .o_match_bit      (o_match_bit),
        .o_parity_bit     (o_parity_bit),
        .o_corrected      (o_corrected),
        .o_interval_empty (o_interval_empty),
        .o_errors_fixed   (o_errors_fixed),
        .o_leaked_bits    (o_leaked_bits)
    );

endmodule

`default_nettype wire

// File: rtl/core/cbs_checker.sv
// Port-level checker for the Cascade binary search step block, with its bind.
`default_nettype none

module cbs_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_valid,
    input wire        i_stall,
    input wire        o_parity_bit,
    input wire        o_corrected,
    input wire        o_interval_empty,
    input wire [15:0] o_errors_fixed
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid set right after reset");

    a_stalled_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_errors_fixed))
        else $error("stalled result changed");

    a_flip_sends_no_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_corrected |-> !o_parity_bit)
        else $error("parity reported on a correcting step");

    a_parity_needs_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_parity_bit |-> !o_interval_empty)
        else $error("parity reported for an empty interval");

endmodule

bind cascade_binary_search_step cbs_checker u_cbs_checker (.*);

`default_nettype wire

// File: sim/cascade_binary_search_step_tb.sv
// Self-checking testbench of the Cascade binary search step block.
`timescale 1ns / 1ps
`default_nettype none

module cascade_binary_search_step_tb;
    import cbs_pkg::*;

    localparam int KEY_N      = 4096;
    localparam int ENT_N      = 256;
    localparam int STALL_MAX  = 13;
    localparam int RAND_ITEMS = 650;
    // The limit is well above one search step over the whole key plus the
    // longest receiver stall.
    localparam int IDLE_LIMIT = 5000;

    // Directed requests are checked against this expected pattern only
    // where the expectation is typed in; otherwise the predictor decides.
    typedef struct {
        logic [1:0]       op;
        logic [POS_W-1:0] bpos;
        logic             bval;
        logic [ENT_W-1:0] ent;
        logic [POS_W-1:0] spos;
        logic [POS_W-1:0] epos;
        logic             rmatch;
        logic             rpar;
        logic             typed;
        logic [3:0]       flags;   // match, parity, corrected, empty
        logic [CNT_W-1:0] fixed;
        logic [CNT_W-1:0] leaked;
    } t_row;

    typedef struct packed {
        logic             match_bit;
        logic             parity_bit;
        logic             corrected;
        logic             interval_empty;
        logic [CNT_W-1:0] errors_fixed;
        logic [CNT_W-1:0] leaked_bits;
    } t_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic [1:0] in_op = OP_KEY_WRITE;
    logic [POS_W-1:0] in_bpos = '0;
    logic in_bval = 1'b0;
    logic [ENT_W-1:0] in_ent = '0;
    logic [POS_W-1:0] in_spos = '0;
    logic [POS_W-1:0] in_epos = '0;
    logic in_rmatch = 1'b0;
    logic in_rpar = 1'b0;
    wire in_stall;
    wire out_valid;
    wire o_m, o_p, o_c, o_e;
    wire [CNT_W-1:0] o_fix, o_leak;

    always #10 clk = ~clk;

    cascade_binary_search_step dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_operation(in_op), .i_bit_position(in_bpos), .i_bit_value(in_bval),
        .i_entry_number(in_ent), .i_start_position(in_spos),
        .i_end_position(in_epos), .i_remote_match(in_rmatch),
        .i_remote_parity(in_rpar),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_match_bit(o_m), .o_parity_bit(o_p), .o_corrected(o_c),
        .o_interval_empty(o_e), .o_errors_fixed(o_fix), .o_leaked_bits(o_leak)
    );

    // Predictor state: its own copy of the key, the interval table and the
    // two saturating counters.
    logic        key_mirror [KEY_N];
    int          lo_mirror [ENT_N];
    int          hi_mirror [ENT_N];
    bit          key_known [KEY_N];
    bit          ent_known [ENT_N];
    int          fixed_cnt, leak_cnt;
    t_result     pending_results [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          sending = 1'b0;

    function automatic logic span_parity(int lo, int hi);
        logic p;
        p = 1'b0;
        for (int i = lo; i <= hi; i++) p ^= key_mirror[i];
        return p;
    endfunction

    function automatic int sat(int v);
        return (v > 65535) ? 65535 : v;
    endfunction

    function automatic void flip_key(int pos);
        key_mirror[pos] = ~key_mirror[pos];
        fixed_cnt = sat(fixed_cnt + 1);
    endfunction

    // Computes the single result of one request and updates the mirror.
    function automatic t_result search_outcome(t_row r);
        t_result res;
        int s, e, mid;
        res = '0;
        if (r.op == OP_KEY_WRITE) begin
            key_mirror[r.bpos] = r.bval;
        end else if (r.op == OP_INSTALL) begin
            lo_mirror[r.ent] = int'(r.spos);
            hi_mirror[r.ent] = (r.epos < r.spos) ? int'(r.spos) - 1 : int'(r.epos);
            res.interval_empty = (r.epos < r.spos);
        end else if (r.op == OP_STEP) begin
            s = lo_mirror[r.ent];
            e = hi_mirror[r.ent];
            if (s <= e) begin
                if (r.rmatch) s = s + (e - s + 1) / 2;
                else e = s + (e - s + 1) / 2 - 1;
            end
            if (s == e) begin
                flip_key(s);
                res.corrected = 1'b1;
                s = e + 1;
            end else if (s < e) begin
                mid = s + (e - s + 1) / 2 - 1;
                if (span_parity(s, mid) == r.rpar) begin
                    s = mid + 1;
                    res.match_bit = 1'b1;
                end else begin
                    e = mid;
                end
                if (s == e) begin
                    flip_key(s);
                    leak_cnt = sat(leak_cnt + 1);
                    res.corrected = 1'b1;
                end else begin
                    mid = s + (e - s + 1) / 2 - 1;
                    res.parity_bit = span_parity(s, mid);
                    leak_cnt = sat(leak_cnt + 2);
                end
            end
            lo_mirror[r.ent] = s;
            hi_mirror[r.ent] = e;
            res.interval_empty = (s > e);
        end
        res.errors_fixed = fixed_cnt[CNT_W-1:0];
        res.leaked_bits = leak_cnt[CNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Sends one request: waits a random gap, then holds valid until accepted.
    task automatic send_request(t_row r);
        t_result res;
        int gap;
        gap = $urandom_range(0, STALL_MAX);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_op <= r.op; in_bpos <= r.bpos; in_bval <= r.bval; in_ent <= r.ent;
        in_spos <= r.spos; in_epos <= r.epos; in_rmatch <= r.rmatch; in_rpar <= r.rpar;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (r.op == OP_KEY_WRITE) key_known[r.bpos] = 1'b1;
        if (r.op == OP_INSTALL) ent_known[r.ent] = 1'b1;
        res = search_outcome(r);
        if (r.typed) begin
            if (res != {r.flags, r.fixed, r.leaked})
                report_mismatch("typed expectation", int'(res), int'({r.flags, r.fixed, r.leaked}));
            res = {r.flags, r.fixed, r.leaked};
        end
        pending_results.push_back(res);
    endtask

    function automatic t_row make_row(logic [1:0] op, int bpos, int bval, int ent,
                                      int spos, int epos, int rm, int rp);
        t_row r;
        r.op = op; r.bpos = POS_W'(bpos); r.bval = 1'(bval); r.ent = ENT_W'(ent);
        r.spos = POS_W'(spos); r.epos = POS_W'(epos); r.rmatch = 1'(rm); r.rpar = 1'(rp);
        r.typed = 1'b0; r.flags = '0; r.fixed = '0; r.leaked = '0;
        return r;
    endfunction

    function automatic t_row typed_row(t_row r, logic [3:0] flags, int fx, int lk);
        r.typed = 1'b1; r.flags = flags; r.fixed = CNT_W'(fx); r.leaked = CNT_W'(lk);
        return r;
    endfunction

    // Random request that only reads key bits and entries already written,
    // since unwritten storage holds nothing defined in the block.
    function automatic t_row random_request();
        t_row r;
        int kind, lo, hi, ent;
        r = make_row(OP_KEY_WRITE, $urandom_range(0, KEY_N - 1), $urandom_range(0, 1),
                     $urandom_range(0, ENT_N - 1), $urandom_range(0, KEY_N - 1),
                     $urandom_range(0, KEY_N - 1), $urandom_range(0, 1),
                     $urandom_range(0, 1));
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            r.op = OP_KEY_WRITE;
        end else if (kind < 4) begin
            // Mostly short intervals so steps stay quick; a few span the key.
            r.op = OP_INSTALL;
            if ($urandom_range(0, 19) == 0) begin
                lo = 0; hi = KEY_N - 1;
            end else begin
                lo = $urandom_range(0, KEY_N - 1);
                hi = lo + $urandom_range(0, 40) - 2;
                if (hi > KEY_N - 1) hi = KEY_N - 1;
                if (hi < 0) hi = 0;
            end
            r.spos = POS_W'(lo); r.epos = POS_W'(hi);
        end else begin
            r.op = OP_STEP;
            ent = -1;
            for (int t = 0; t < 8 && ent < 0; t++) begin
                if (ent_known[r.ent]) ent = int'(r.ent);
                else r.ent = ENT_W'($urandom_range(0, ENT_N - 1));
            end
            if (ent < 0) r.op = OP_KEY_WRITE;
        end
        // Reading an undefined key bit is avoided: any touched span must be known.
        if (r.op == OP_STEP) begin
            for (int i = lo_mirror[r.ent]; i <= hi_mirror[r.ent]; i++)
                if (!key_known[i]) r.op = OP_KEY_WRITE;
        end
        if (r.op == OP_INSTALL) begin
            for (int i = int'(r.spos); i <= int'(r.epos); i++)
                if (!key_known[i]) begin
                    r = make_row(OP_KEY_WRITE, i, $urandom_range(0, 1), 0, 0, 0, 0, 0);
                    break;
                end
        end
        return r;
    endfunction

    // Result side: a random wait per result, compare each accepted result in order.
    always @(posedge clk) begin
        t_result got, want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = {o_m, o_p, o_c, o_e, o_fix, o_leak};
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", int'(got), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.match_bit !== want.match_bit)
                        report_mismatch("match_bit", int'(got.match_bit),
                                        int'(want.match_bit));
                    if (got.parity_bit !== want.parity_bit)
                        report_mismatch("parity_bit", int'(got.parity_bit),
                                        int'(want.parity_bit));
                    if (got.corrected !== want.corrected)
                        report_mismatch("corrected", int'(got.corrected),
                                        int'(want.corrected));
                    if (got.interval_empty !== want.interval_empty)
                        report_mismatch("interval_empty", int'(got.interval_empty),
                                        int'(want.interval_empty));
                    if (got.errors_fixed !== want.errors_fixed)
                        report_mismatch("errors_fixed", int'(got.errors_fixed),
                                        int'(want.errors_fixed));
                    if (got.leaked_bits !== want.leaked_bits)
                        report_mismatch("leaked_bits", int'(got.leaked_bits),
                                        int'(want.leaked_bits));
                end
                stall_left = $urandom_range(0, STALL_MAX);
            end else if (out_valid && out_stall && stall_left > 0) begin
                stall_left--;
            end
            out_stall <= (stall_left > 0);
        end
    end

    // Watchdog: counts cycles in which neither side accepts anything.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        for (int i = 0; i < KEY_N; i++) begin
            key_mirror[i] = 1'b0; key_known[i] = 1'b0;
        end
        for (int i = 0; i < ENT_N; i++) begin
            lo_mirror[i] = 0; hi_mirror[i] = -1; ent_known[i] = 1'b0;
        end
        fixed_cnt = 0; leak_cnt = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extreme positions, every operation, an unused code,
        // an install with start after end, a single-bit interval and
        // intervals of two, three and eight bits.
        rows.push_back(typed_row(make_row(OP_KEY_WRITE, 0, 1, 0, 0, 0, 0, 0), 4'b0000, 0, 0));
        rows.push_back(typed_row(make_row(OP_KEY_WRITE, 4095, 1, 255, 4095, 4095, 1, 1),
                                 4'b0000, 0, 0));
        for (int i = 1; i < 8; i++)
            rows.push_back(make_row(OP_KEY_WRITE, i, i % 2, 0, 0, 0, 0, 0));
        rows.push_back(typed_row(make_row(2'd3, 4095, 1, 255, 4095, 4095, 1, 1),
                                 4'b0000, 0, 0));
        rows.push_back(typed_row(make_row(OP_INSTALL, 0, 0, 255, 4095, 0, 0, 0),
                                 4'b0001, 0, 0));
        rows.push_back(typed_row(make_row(OP_STEP, 0, 0, 255, 0, 0, 1, 1), 4'b0001, 0, 0));
        rows.push_back(typed_row(make_row(OP_INSTALL, 0, 0, 0, 4095, 4095, 0, 0),
                                 4'b0000, 0, 0));
        rows.push_back(make_row(OP_STEP, 0, 0, 0, 0, 0, 1, 0));
        rows.push_back(make_row(OP_INSTALL, 0, 0, 1, 0, 1, 0, 0));
        rows.push_back(make_row(OP_STEP, 0, 0, 1, 0, 0, 0, 1));
        rows.push_back(make_row(OP_INSTALL, 0, 0, 2, 0, 7, 0, 0));
        rows.push_back(make_row(OP_STEP, 0, 0, 2, 0, 0, 0, 0));
        rows.push_back(make_row(OP_STEP, 0, 0, 2, 0, 0, 1, 1));
        rows.push_back(make_row(OP_STEP, 0, 0, 2, 0, 0, 0, 0));
        rows.push_back(make_row(OP_INSTALL, 0, 0, 3, 1, 3, 0, 0));
        rows.push_back(make_row(OP_STEP, 0, 0, 3, 0, 0, 1, 0));
        foreach (rows[i]) send_request(rows[i]);

        for (int n = 0; n < RAND_ITEMS; n++) send_request(random_request());
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire
